FILE: rtl/tsched_pkg.sv
`timescale 1ns / 1ps

package tsched_pkg;

   localparam int MAX_TASKS = 64;
   localparam int IDX_W     = $clog2(MAX_TASKS);
   localparam int CNT_W     = $clog2(MAX_TASKS + 1);

   localparam int PRIO_W    = 7;
   localparam int BURST_W   = 8;
   localparam int SLICE_W   = 8;
   localparam int TIDX_W    = 6;
   localparam int POLICY_W  = 2;
   localparam int QUANTUM_W = 4;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 4;
   localparam int STAT_W    = PRIO_W + BURST_W;

   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_STEP = 1'b1;

   localparam logic [POLICY_W-1:0] POL_FCFS = 2'd0;
   localparam logic [POLICY_W-1:0] POL_PRIO = 2'd1;
   localparam logic [POLICY_W-1:0] POL_RR   = 2'd2;
   localparam logic [POLICY_W-1:0] POL_SJF  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_POLICY  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUANTUM = 1'd1;

   localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 4'd2;

   typedef enum logic [1:0] {
      STAT_RUN    = 2'd0,
      STAT_ADDED  = 2'd1,
      STAT_FULL   = 2'd2,
      STAT_NOWORK = 2'd3
   } status_type;

   typedef struct packed {
      logic               found;
      logic [IDX_W-1:0]   idx;
      logic [BURST_W-1:0] rem;
   } best_type;

endpackage

FILE: rtl/tsched_if.sv
`timescale 1ns / 1ps

interface tsched_req_if import tsched_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               operation;
   logic [PRIO_W-1:0]  task_priority;
   logic [BURST_W-1:0] task_burst;

   modport source (output valid, operation, task_priority, task_burst, input ready);
   modport sink   (input valid, operation, task_priority, task_burst, output ready);
endinterface

interface tsched_rsp_if import tsched_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic [TIDX_W-1:0]  task_index;
   logic [SLICE_W-1:0] slice_number;
   logic               task_finished;

   modport source (output valid, status, task_index, slice_number, task_finished,
                   input ready);
   modport sink   (input valid, status, task_index, slice_number, task_finished,
                   output ready);
endinterface

interface tsched_csr_if import tsched_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/tsched_ram.sv
`timescale 1ns / 1ps

module tsched_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/tsched_cmp.sv
`timescale 1ns / 1ps

module tsched_cmp import tsched_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               clear,
   input  logic               sample,
   input  logic [IDX_W-1:0]   idx,
   input  logic [BURST_W-1:0] key,
   input  logic [BURST_W-1:0] rem,
   output best_type           best
);

   logic               found_ff, found_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [BURST_W-1:0] key_ff, key_in;
   logic [BURST_W-1:0] rem_ff, rem_in;
   logic               take;

   assign take = sample && (rem != '0) && (!found_ff || (key < key_ff));

   always_comb begin
      found_in = found_ff;
      idx_in   = idx_ff;
      key_in   = key_ff;
      rem_in   = rem_ff;
      if (clear) begin
         found_in = 1'b0;
      end else if (take) begin
         found_in = 1'b1;
         idx_in   = idx;
         key_in   = key;
         rem_in   = rem;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      idx_ff <= idx_in;
      key_ff <= key_in;
      rem_ff <= rem_in;
   end

   assign best.found = found_ff;
   assign best.idx   = idx_ff;
   assign best.rem   = rem_ff;

endmodule

FILE: rtl/task_scheduler_fcfs_prio_rr_sjf.sv
`timescale 1ns / 1ps

// channel   dir  handshake      payload
// req_ch    in   valid/ready    operation, task_priority, task_burst
// rsp_ch    out  valid/ready    status, task_index, slice_number, task_finished
// csr_ch    in   valid/ready    index (0 policy_mode, 1 time_quantum), data
//
// Add: IDLE writes if not full, then EMIT. Continuing step: IDLE, CHK, EMIT.
// Step that picks a task: one comparator scans the table, one entry a cycle
// through the registered RAM read; when a task is running, its entry is
// checked first (ST_CHK) and the scan starts only if it cannot continue.
// Synchronous active-high reset; the task table needs no clearing pass.
// A new word is taken once the previous result sits in the output register.

module task_scheduler_fcfs_prio_rr_sjf import tsched_pkg::*; (
   input logic           clock,
   input logic           reset,
   tsched_req_if.sink    req_ch,
   tsched_rsp_if.source  rsp_ch,
   tsched_csr_if.sink    csr_ch
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHK,
      ST_SCAN,
      ST_EMIT
   } state_type;

   state_type            state_ff, state_in;
   logic [POLICY_W-1:0]  policy_ff, policy_in;
   logic [QUANTUM_W-1:0] quantum_ff, quantum_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [IDX_W-1:0]     cur_ff, cur_in;
   logic                 cur_valid_ff, cur_valid_in;
   logic [SLICE_W-1:0]   slice_ff, slice_in;
   logic [CNT_W-1:0]     pos_ff, pos_in;
   logic [CNT_W-1:0]     issued_ff, issued_in;
   logic                 dv_ff, dv_in;
   logic [IDX_W-1:0]     dpos_ff, dpos_in;

   status_type           res_status_ff, res_status_in;
   logic [IDX_W-1:0]     res_idx_ff, res_idx_in;
   logic [SLICE_W-1:0]   res_slice_ff, res_slice_in;
   logic                 res_fin_ff, res_fin_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic [TIDX_W-1:0]    rsp_idx_ff, rsp_idx_in;
   logic [SLICE_W-1:0]   rsp_slice_ff, rsp_slice_in;
   logic                 rsp_fin_ff, rsp_fin_in;

   logic                 stat_we, rem_we;
   logic [IDX_W-1:0]     waddr, raddr;
   logic [STAT_W-1:0]    stat_wdata, stat_rdata;
   logic [BURST_W-1:0]   rem_wdata, rem_rdata;
   logic [PRIO_W-1:0]    rd_prio;
   logic [BURST_W-1:0]   rd_orig;
   logic [BURST_W-1:0]   cmp_key;
   logic                 cmp_clear;
   best_type             best;

   logic                 req_fire;
   logic                 csr_fire;
   logic [QUANTUM_W-1:0] q_eff;
   logic [CNT_W-1:0]     cur_next;
   logic [CNT_W-1:0]     start_pos;
   logic [CNT_W-1:0]     pos_next;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign csr_fire     = csr_ch.valid && csr_ch.ready;

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = rsp_status_ff;
   assign rsp_ch.task_index    = rsp_idx_ff;
   assign rsp_ch.slice_number  = rsp_slice_ff;
   assign rsp_ch.task_finished = rsp_fin_ff;

   assign q_eff     = (quantum_ff == '0) ? QUANTUM_W'(1) : quantum_ff;
   assign cur_next  = CNT_W'(cur_ff) + CNT_W'(1);
   assign start_pos = (policy_ff == POL_RR && cur_valid_ff && cur_next != count_ff)
                      ? cur_next : '0;
   assign pos_next  = (pos_ff + CNT_W'(1) == count_ff) ? '0 : pos_ff + CNT_W'(1);

   assign rd_prio = stat_rdata[STAT_W-1 -: PRIO_W];
   assign rd_orig = stat_rdata[BURST_W-1:0];

   always_comb begin
      case (policy_ff)
         POL_PRIO: cmp_key = BURST_W'(rd_prio);
         POL_SJF:  cmp_key = rd_orig;
         default:  cmp_key = '0;
      endcase
   end

   tsched_ram #(.WIDTH(STAT_W), .DEPTH(MAX_TASKS)) u_stat_ram (
      .clock (clock),
      .we    (stat_we),
      .waddr (waddr),
      .wdata (stat_wdata),
      .raddr (raddr),
      .rdata (stat_rdata)
   );

   tsched_ram #(.WIDTH(BURST_W), .DEPTH(MAX_TASKS)) u_rem_ram (
      .clock (clock),
      .we    (rem_we),
      .waddr (waddr),
      .wdata (rem_wdata),
      .raddr (raddr),
      .rdata (rem_rdata)
   );

   tsched_cmp u_cmp (
      .clock  (clock),
      .reset  (reset),
      .clear  (cmp_clear),
      .sample (dv_ff),
      .idx    (dpos_ff),
      .key    (cmp_key),
      .rem    (rem_rdata),
      .best   (best)
   );

   always_comb begin
      logic begin_scan;
      begin_scan    = 1'b0;
      state_in      = state_ff;
      policy_in     = policy_ff;
      quantum_in    = quantum_ff;
      count_in      = count_ff;
      cur_in        = cur_ff;
      cur_valid_in  = cur_valid_ff;
      slice_in      = slice_ff;
      pos_in        = pos_ff;
      issued_in     = issued_ff;
      dv_in         = 1'b0;
      dpos_in       = dpos_ff;
      res_status_in = res_status_ff;
      res_idx_in    = res_idx_ff;
      res_slice_in  = res_slice_ff;
      res_fin_in    = res_fin_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_slice_in  = rsp_slice_ff;
      rsp_fin_in    = rsp_fin_ff;
      stat_we       = 1'b0;
      rem_we        = 1'b0;
      waddr         = cur_ff;
      stat_wdata    = {req_ch.task_priority, req_ch.task_burst};
      rem_wdata     = req_ch.task_burst;
      raddr         = cur_ff;
      cmp_clear     = 1'b0;

      if (csr_fire) begin
         case (csr_ch.index)
            CSR_POLICY:  policy_in  = POLICY_W'(csr_ch.data);
            CSR_QUANTUM: quantum_in = csr_ch.data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_ch.operation == OP_ADD) begin
                  res_slice_in = '0;
                  res_fin_in   = 1'b0;
                  if (count_ff == CNT_W'(MAX_TASKS)) begin
                     res_status_in = STAT_FULL;
                     res_idx_in    = '0;
                  end else begin
                     stat_we       = 1'b1;
                     rem_we        = 1'b1;
                     waddr         = count_ff[IDX_W-1:0];
                     res_status_in = STAT_ADDED;
                     res_idx_in    = count_ff[IDX_W-1:0];
                     count_in      = count_ff + CNT_W'(1);
                  end
                  state_in = ST_EMIT;
               end else if (cur_valid_ff) begin
                  state_in = ST_CHK;
               end else begin
                  begin_scan = 1'b1;
               end
            end
         end
         ST_CHK: begin
            if (rem_rdata != '0 &&
                !(policy_ff == POL_RR && slice_ff >= SLICE_W'(q_eff))) begin
               slice_in      = slice_ff + SLICE_W'(1);
               rem_we        = 1'b1;
               rem_wdata     = rem_rdata - BURST_W'(1);
               res_status_in = STAT_RUN;
               res_idx_in    = cur_ff;
               res_slice_in  = slice_ff + SLICE_W'(1);
               res_fin_in    = (rem_rdata == BURST_W'(1));
               state_in      = ST_EMIT;
            end else begin
               begin_scan = 1'b1;
            end
         end
         ST_SCAN: begin
            raddr = pos_ff[IDX_W-1:0];
            if (issued_ff != count_ff) begin
               pos_in    = pos_next;
               issued_in = issued_ff + CNT_W'(1);
               dv_in     = 1'b1;
               dpos_in   = pos_ff[IDX_W-1:0];
            end else if (!dv_ff) begin
               if (!best.found) begin
                  cur_valid_in  = 1'b0;
                  res_status_in = STAT_NOWORK;
                  res_idx_in    = '0;
                  res_slice_in  = '0;
                  res_fin_in    = 1'b0;
               end else begin
                  cur_in        = best.idx;
                  cur_valid_in  = 1'b1;
                  slice_in      = SLICE_W'(1);
                  rem_we        = 1'b1;
                  waddr         = best.idx;
                  rem_wdata     = best.rem - BURST_W'(1);
                  res_status_in = STAT_RUN;
                  res_idx_in    = best.idx;
                  res_slice_in  = SLICE_W'(1);
                  res_fin_in    = (best.rem == BURST_W'(1));
               end
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_idx_in    = TIDX_W'(res_idx_ff);
               rsp_slice_in  = res_slice_ff;
               rsp_fin_in    = res_fin_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (begin_scan) begin
         if (count_ff == '0) begin
            cur_valid_in  = 1'b0;
            res_status_in = STAT_NOWORK;
            res_idx_in    = '0;
            res_slice_in  = '0;
            res_fin_in    = 1'b0;
            state_in      = ST_EMIT;
         end else begin
            pos_in    = start_pos;
            issued_in = '0;
            cmp_clear = 1'b1;
            state_in  = ST_SCAN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         policy_ff    <= POL_FCFS;
         quantum_ff   <= QUANTUM_RESET;
         count_ff     <= '0;
         cur_ff       <= '0;
         cur_valid_ff <= 1'b0;
         slice_ff     <= '0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         policy_ff    <= policy_in;
         quantum_ff   <= quantum_in;
         count_ff     <= count_in;
         cur_ff       <= cur_in;
         cur_valid_ff <= cur_valid_in;
         slice_ff     <= slice_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff        <= pos_in;
      issued_ff     <= issued_in;
      dpos_ff       <= dpos_in;
      res_status_ff <= res_status_in;
      res_idx_ff    <= res_idx_in;
      res_slice_ff  <= res_slice_in;
      res_fin_ff    <= res_fin_in;
      rsp_status_ff <= rsp_status_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_slice_ff  <= rsp_slice_in;
      rsp_fin_ff    <= rsp_fin_in;
   end

endmodule
